// ----- rtl/core/tccw_pkg.sv -----
// Shared constants for the text console cell writer.
// Field widths, control character codes, cell patterns and register map.
// No dependencies.
package tccw_pkg;

	// Fixed field widths of the ports
	localparam int POS_W   = 11;
	localparam int CHAR_W  = 8;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Item operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Register index (paddr bit above the byte lanes)
	localparam logic REG_ATTR = 1'b0;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

	// Cell patterns
	localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;
	localparam logic [CELL_W-1:0] ERASED_CELL = 16'h0F00;
	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;

endpackage

// ----- rtl/core/tccw_modu.sv -----
// Remainder unit: operand modulo COLUMNS or TAB_STOP by reciprocal multiplication.
// One shared multiplier, two passes: quotient, then quotient times the divisor.
// Uses tccw_pkg (wildcard import); no submodules.
module tccw_modu
	import tccw_pkg::*;
#(
	parameter int W        = 11,
	parameter int COLUMNS  = 80,
	parameter int TAB_STOP = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  by_tab,
	input  logic [W-1:0]          operand,
	output logic                  busy,
	output logic [$clog2((COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP):0] rem
);

	localparam int DMAX = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
	localparam int RW   = $clog2(DMAX) + 1;
	// Shift that keeps floor(x * M / 2^SH) exact for every W-bit x
	localparam int SH   = W + $clog2(DMAX);
	localparam int PW   = W + SH;
	localparam logic [SH-1:0] M_COL =
		SH'(((longint'(1) << SH) + COLUMNS - 1) / COLUMNS);
	localparam logic [SH-1:0] M_TAB =
		SH'(((longint'(1) << SH) + TAB_STOP - 1) / TAB_STOP);

	typedef enum logic [2:0] {
		P_IDLE = 3'b001,
		P_QUOT = 3'b010,
		P_BACK = 3'b100
	} pass_t;

	pass_t         pass_q;
	logic          tab_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  quot_q;
	logic [RW-1:0] r_q;
	logic [W-1:0]  mul_a;
	logic [SH-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [W-1:0]  diff;

	// Pass one: operand times the reciprocal; pass two: quotient times the divisor
	assign mul_a = (pass_q == P_BACK) ? quot_q : x_q;
	assign mul_b = (pass_q == P_BACK) ?
		(tab_q ? SH'(TAB_STOP) : SH'(COLUMNS)) :
		(tab_q ? M_TAB : M_COL);
	assign prod  = PW'(mul_a) * PW'(mul_b);
	assign diff  = x_q - prod[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= P_IDLE;
		end else if (start) begin
			pass_q <= P_QUOT;
		end else begin
			case (pass_q)
				P_QUOT: begin
					pass_q <= P_BACK;
				end
				P_BACK: begin
					pass_q <= P_IDLE;
				end
				default: begin
					pass_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= operand;
			tab_q <= by_tab;
		end
		if (pass_q == P_QUOT) begin
			quot_q <= prod[SH +: W];
		end
		if (pass_q == P_BACK) begin
			r_q <= RW'(diff);
		end
	end

	assign busy = (pass_q != P_IDLE);
	assign rem  = r_q;

endmodule

// ----- rtl/core/tccw_store.sv -----
// Screen cell memory: one write port, one registered read port, clear sweep after reset.
// Uses tccw_pkg (wildcard import) for the blank cell pattern.
module tccw_store
	import tccw_pkg::*;
#(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata,
	output logic              clearing
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;
	logic              clr_q;
	logic [AW-1:0]     clr_addr_q;

	// Sweep every entry to blank once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= BLANK_CELL;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clr_q;

endmodule

// ----- rtl/core/text_console_cell_writer.sv -----
// Text console cell writer: top level with sequencer, cursor state and config port.
// Uses tccw_pkg (wildcard import), tccw_modu and tccw_store.
//
//   port group      direction  beat taken when           carries
//   in_*            in         in_valid & !in_stall      opcode, char_code, cell_index
//   out_*           out        out_valid & !out_stall    cursor_pos, read_data
//   APB             in/out     psel&penable&pwrite       text_attribute at paddr 0
//
// Path of an item from accept to idle: a read goes through S_RD and S_DONE; any
// other item through S_CHK and S_DISP, then a backspace through S_BS and a tab,
// newline or carriage return through S_MOD, which waits out the two passes of the
// remainder unit through its one multiplier; all end in S_DONE. A scroll blanks
// the freed row through the single memory write port. After reset all COLUMNS*ROWS
// cells (2000 at 80x25) are swept to blank; in_stall stays high during the sweep.
// The output register lets a new beat be accepted while the last result waits;
// a finished item holds in its final state only until that register frees up.
module text_console_cell_writer
	import tccw_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [POS_W-1:0]   cell_index,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [POS_W-1:0]   cursor_pos,
	output logic [CELL_W-1:0]  read_data,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(CELLS + 1);          // cursor may reach CELLS
	localparam int AW    = $clog2(CELLS);
	localparam int DMAX  = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
	localparam int RW    = $clog2(DMAX) + 1;
	localparam int SCW   = $clog2(COLUMNS);
	localparam int IXW   = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CHK  = 8'b0000_0010,
		S_SCRL = 8'b0000_0100,
		S_DISP = 8'b0000_1000,
		S_MOD  = 8'b0001_0000,
		S_BS   = 8'b0010_0000,
		S_RD   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cursor_q;
	logic [CW-1:0]     floor_q;
	logic [AW-1:0]     base_q;        // physical cell of logical cell 0
	logic [SCW-1:0]    scl_q;
	logic              scrl_done_q;   // after the scroll, finish instead of dispatch
	logic [ATTR_W-1:0] attr_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic [CELL_W-1:0] read_data_q;
	logic              op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  idx_q;

	logic              clearing;
	logic              in_range;
	logic              out_free;
	logic              cfg_wr;
	logic [CW-1:0]     logical;
	logic [AW:0]       phys_sum;
	logic [AW-1:0]     phys;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [CELL_W-1:0] mem_rdata;
	logic              mod_start;
	logic              mod_by_tab;
	logic              mod_busy;
	logic [RW-1:0]     mod_rem;
	logic [CW:0]       tab_sum;
	logic [CW-1:0]     line_start;
	logic [CW-1:0]     next_line;
	logic [AW:0]       base_next;

	tccw_modu #(
		.W        (CW),
		.COLUMNS  (COLUMNS),
		.TAB_STOP (TAB_STOP)
	) u_modu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.by_tab  (mod_by_tab),
		.operand (cursor_q),
		.busy    (mod_busy),
		.rem     (mod_rem)
	);

	tccw_store #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.re       (mem_re),
		.raddr    (phys),
		.rdata    (mem_rdata),
		.clearing (clearing)
	);

	// Configuration: one register, byte lanes ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ATTR);
	assign prdata = (paddr[PADDR_W-1] == REG_ATTR) ?
		{{(PDATA_W-ATTR_W){1'b0}}, attr_q} : '0;

	// Handshakes
	assign in_stall  = (state_q != S_IDLE) || clearing;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign read_data  = read_data_q;

	assign in_range = IXW'(idx_q) < IXW'(CELLS);

	// Screen rows live in a ring: logical cell plus base, wrapped once
	assign logical  = (state_q == S_RD) ? CW'(idx_q) : cursor_q;
	assign phys_sum = {1'b0, logical[AW-1:0]} + {1'b0, base_q};
	assign phys     = (phys_sum >= (AW+1)'(CELLS)) ?
		AW'(phys_sum - (AW+1)'(CELLS)) : phys_sum[AW-1:0];
	assign base_next = {1'b0, base_q} + (AW+1)'(COLUMNS);

	// Cursor targets once the remainder is in
	assign tab_sum    = (CW+1)'(cursor_q) + (CW+1)'(TAB_STOP) - (CW+1)'(mod_rem);
	assign line_start = cursor_q - CW'(mod_rem);
	assign next_line  = line_start + CW'(COLUMNS);

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = phys;
		mem_wdata  = BLANK_CELL;
		mem_re     = 1'b0;
		mod_start  = 1'b0;
		mod_by_tab = 1'b0;
		case (state_q)
			S_SCRL: begin
				// blank the old top row, which becomes the new bottom row
				mem_we    = 1'b1;
				mem_waddr = base_q + AW'(scl_q);
			end
			S_DISP: begin
				if (ch_q == CH_TAB) begin
					mod_start  = 1'b1;
					mod_by_tab = 1'b1;
				end else if (ch_q == CH_LF || ch_q == CH_CR) begin
					mod_start = 1'b1;
				end else if (ch_q != CH_NUL && ch_q != CH_BS &&
					cursor_q < CW'(CELLS)) begin
					mem_we    = 1'b1;
					mem_wdata = {attr_q, ch_q};
				end
			end
			S_BS: begin
				if (cursor_q < CW'(CELLS)) begin
					mem_we    = 1'b1;
					mem_wdata = ERASED_CELL;
				end
			end
			S_RD: begin
				mem_re = in_range;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			floor_q     <= '0;
			base_q      <= '0;
			scl_q       <= '0;
			scrl_done_q <= 1'b0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				attr_q <= pwdata[ATTR_W-1:0];
			end

			// Load a finished result, else drop a taken one
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && !clearing) begin
						state_q <= (opcode == OP_READ) ? S_RD : S_CHK;
					end
				end
				S_CHK: begin
					if (cursor_q >= CW'(CELLS - 1)) begin
						scrl_done_q <= 1'b0;
						state_q     <= S_SCRL;
					end else begin
						state_q <= S_DISP;
					end
				end
				S_SCRL: begin
					scl_q <= scl_q + 1'b1;
					if (scl_q == SCW'(COLUMNS - 1)) begin
						scl_q    <= '0;
						base_q   <= (base_next == (AW+1)'(CELLS)) ? '0 : base_next[AW-1:0];
						cursor_q <= (cursor_q >= CW'(COLUMNS)) ?
							cursor_q - CW'(COLUMNS) : '0;
						floor_q  <= (floor_q >= CW'(COLUMNS)) ?
							floor_q - CW'(COLUMNS) : '0;
						state_q  <= scrl_done_q ? S_DONE : S_DISP;
					end
				end
				S_DISP: begin
					if (ch_q == CH_NUL) begin
						state_q <= S_DONE;
					end else if (ch_q == CH_TAB || ch_q == CH_LF || ch_q == CH_CR) begin
						state_q <= S_MOD;
					end else if (ch_q == CH_BS) begin
						if (floor_q < cursor_q) begin
							cursor_q <= cursor_q - 1'b1;
						end
						state_q <= S_BS;
					end else begin
						if (cursor_q < CW'(CELLS)) begin
							cursor_q <= cursor_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_MOD: begin
					if (!mod_busy) begin
						if (ch_q == CH_TAB) begin
							cursor_q <= (tab_sum > (CW+1)'(CELLS)) ?
								CW'(CELLS) : tab_sum[CW-1:0];
							state_q  <= S_DONE;
						end else if (ch_q == CH_LF) begin
							cursor_q <= next_line;
							floor_q  <= next_line;
							if (next_line > CW'(CELLS - COLUMNS)) begin
								scrl_done_q <= 1'b1;
								state_q     <= S_SCRL;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							cursor_q <= line_start;
							floor_q  <= line_start;
							state_q  <= S_DONE;
						end
					end
				end
				S_BS: begin
					state_q <= S_DONE;
				end
				S_RD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: latch the beat, fill the result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !clearing) begin
			op_q  <= opcode;
			ch_q  <= char_code;
			idx_q <= cell_index;
		end
		if (state_q == S_DONE && out_free) begin
			cursor_pos_q <= POS_W'(cursor_q);
			read_data_q  <= (op_q == OP_READ && in_range) ? mem_rdata : '0;
		end
	end

endmodule

// ----- verif/tccw_checker.sv -----
`timescale 1ns / 1ps
// Checker for the text console cell writer: mirrors cursor, edit floor, attribute and
// screen, predicts each result beat and compares it. Depends on tccw_pkg.
module tccw_checker
	import tccw_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               opcode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [POS_W-1:0]   cell_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [POS_W-1:0]   cursor_pos,
	input  logic [CELL_W-1:0]  read_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] data;
	} console_reply_t;

	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       cur;
	int unsigned       floor_pos;
	logic [ATTR_W-1:0] attr;
	console_reply_t    reply_q [$];
	console_reply_t    want;
	console_reply_t    fresh;
	int unsigned       taken;
	int unsigned       returned;
	int                k;

	assign pending = int'(taken - returned);

	initial errors = 0;

	task automatic flag_mismatch(input string what, input int got, input int wanted);
		$display("%0t tccw_checker: %s: got %0h, want %0h", $time, what, got, wanted);
		errors++;
	endtask

	task automatic scroll_screen();
		int i;
		for (i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = BLANK_CELL;
		cur       = (cur >= COLUMNS) ? cur - COLUMNS : 0;
		floor_pos = (floor_pos >= COLUMNS) ? floor_pos - COLUMNS : 0;
	endtask

	task automatic feed_char(input logic [CHAR_W-1:0] ch);
		if (cur >= CELLS - 1)
			scroll_screen();
		case (ch)
			CH_NUL: ;
			CH_TAB: begin
				cur = cur + TAB_STOP - (cur % TAB_STOP);
				if (cur > CELLS)
					cur = CELLS;
			end
			CH_LF: begin
				cur       = cur - (cur % COLUMNS) + COLUMNS;
				floor_pos = cur;
				if (cur > CELLS - COLUMNS)
					scroll_screen();
			end
			CH_CR: begin
				cur       = cur - (cur % COLUMNS);
				floor_pos = cur;
			end
			CH_BS: begin
				if (floor_pos < cur)
					cur--;
				if (cur < CELLS)
					screen[cur] = ERASED_CELL;
			end
			default: begin
				if (cur < CELLS) begin
					screen[cur] = {attr, ch};
					cur++;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < CELLS; k++)
				screen[k] = BLANK_CELL;
			cur       = 0;
			floor_pos = 0;
			attr      = ATTR_RESET;
			reply_q.delete();
			taken    <= 0;
			returned <= 0;
		end else begin
			// older items first: a result never belongs to a beat taken at the same edge
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					flag_mismatch("result beat with nothing expected", cursor_pos, 0);
				end else begin
					want = reply_q.pop_front();
					returned <= returned + 1;
					if (cursor_pos !== want.pos)
						flag_mismatch("cursor_pos", cursor_pos, want.pos);
					if (read_data !== want.data)
						flag_mismatch("read_data", read_data, want.data);
				end
			end
			if (in_valid && !in_stall) begin
				fresh.data = '0;
				if (opcode == OP_WRITE)
					feed_char(char_code);
				else if (cell_index < CELLS)
					fresh.data = screen[cell_index];
				fresh.pos = cur[POS_W-1:0];
				reply_q.push_back(fresh);
				taken <= taken + 1;
			end
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ATTR) begin
				if (pwrite)
					attr = pwdata[ATTR_W-1:0];
				else if (prdata !== PDATA_W'(attr))
					flag_mismatch("prdata", prdata, attr);
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the text console cell writer: clock, reset, item and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on tccw_pkg, text_console_cell_writer and tccw_checker.
module tb
	import tccw_pkg::*;
();

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 4;
	// Worst single item: remainder pass plus blanking a freed row, taken twice over
	localparam int SETTLE      = 2 * (COLUMNS + 32);
	// Longest quiet stretch is the blanking sweep after reset; allow several of them
	localparam int STALL_LIMIT = 5 * COLUMNS * ROWS;
	localparam int PHASE_ITEMS = 390;
	localparam int TAIL_ITEMS  = 150;
	localparam logic [PADDR_W-1:0] ATTR_ADDR  = {REG_ATTR, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_ATTR, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic [CHAR_W-1:0]  char_code;
	logic [POS_W-1:0]   cell_index;
	logic               out_valid;
	logic               out_stall;
	logic [POS_W-1:0]   cursor_pos;
	logic [CELL_W-1:0]  read_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int   errors;
	int   pending;
	int   idle_cycles;
	logic quiet;  // end of run: no idling on either side
	logic calm;   // idle-free stretch inside the random part

	text_console_cell_writer #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_pos (cursor_pos),
		.read_data  (read_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	tccw_checker #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_pos (cursor_pos),
		.read_data  (read_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one beat and hold it until taken. A gap drops valid first; without a
	// gap valid stays high straight into the next beat.
	task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
			input logic [POS_W-1:0] idx);
		if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		cell_index <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic put(input logic [CHAR_W-1:0] ch);
		send_item(OP_WRITE, ch, POS_W'($urandom_range(0, 2047)));
	endtask

	task automatic peek(input logic [POS_W-1:0] idx);
		send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drop valid and let every expected result drain, then wait out the SETTLE time;
	// a row move is already done by the time the result of its item is taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random part built from well-formed runs: text lines, tab runs, backspace
	// runs, newline runs and reads, with a little noise of arbitrary items.
	task automatic run_random(input int count);
		int n;
		int kind;
		int len;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 99);
			calm = ($urandom_range(0, 3) == 0);
			if (kind < 45) begin
				len = $urandom_range(1, 40);
				repeat (len) put(CHAR_W'($urandom_range(8'h20, 8'hFF)));
				put(($urandom_range(0, 3) == 0) ? CH_CR : CH_LF);
				n += len + 1;
			end else if (kind < 60) begin
				len = $urandom_range(1, 24);
				repeat (len) put(CH_TAB);
				n += len;
			end else if (kind < 72) begin
				len = $urandom_range(1, 8);
				repeat (len) put(CH_BS);
				n += len;
			end else if (kind < 86) begin
				len = $urandom_range(1, 4);
				repeat (len) begin
					if ($urandom_range(0, 1) == 0)
						peek(POS_W'($urandom_range(0, 2047)));
					else
						peek(POS_W'($urandom_range(COLUMNS * (ROWS - 2), COLUMNS * ROWS - 1)));
				end
				n += len;
			end else if (kind < 93) begin
				len = $urandom_range(1, 6);
				repeat (len) put(CH_LF);
				n += len;
			end else begin
				len = $urandom_range(1, 3);
				repeat (len)
					send_item(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
						POS_W'($urandom_range(0, 2047)));
				n += len;
			end
		end
		calm = 1'b0;
	endtask

	// Result back-pressure: random stall bursts, none in calm stretches or at the
	// end of the run.
	initial begin
		int burst;
		burst     = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
			end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(1, 6) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no beat moves on any port for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_WRITE;
		char_code  = '0;
		cell_index = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		quiet      = 1'b0;
		calm       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// check the attribute reset value
		apb_access(1'b0, ATTR_ADDR, '0);

		// Directed part with the reset attribute: out-of-range reads, both byte
		// extremes, NUL, backspace above and at the edit floor, tab, carriage
		// return and newline.
		peek(POS_W'(0));
		peek(POS_W'(COLUMNS * ROWS - 1));
		peek(POS_W'(2047));
		peek(POS_W'(COLUMNS * ROWS));
		put(8'hFF);
		put(8'h20);
		put(CH_NUL);
		put(CH_BS);
		peek(POS_W'(1));
		put(CH_BS);
		put(CH_BS);
		put(CH_TAB);
		put(8'h01);
		put(CH_TAB);
		put(CH_CR);
		put(CH_LF);
		put(CH_BS);
		put(8'h7F);
		put(8'h80);
		put(CH_LF);
		peek(POS_W'(COLUMNS + 1));
		peek(POS_W'(0));
		drain();

		// attribute all zeros, upper data bits set
		apb_access(1'b1, ATTR_ADDR, 32'hFFFF_FF00);
		apb_access(1'b0, ATTR_ADDR, '0);
		run_random(PHASE_ITEMS);
		drain();

		// attribute all ones
		apb_access(1'b1, ATTR_ADDR, 32'h0000_00FF);
		apb_access(1'b0, ATTR_ADDR, '0);
		run_random(PHASE_ITEMS);
		drain();

		// a write to the unused slot must leave the attribute alone
		apb_access(1'b1, SPARE_ADDR, $urandom);
		apb_access(1'b0, ATTR_ADDR, '0);
		apb_access(1'b1, ATTR_ADDR, $urandom);
		apb_access(1'b0, ATTR_ADDR, '0);
		run_random(PHASE_ITEMS - TAIL_ITEMS);
		quiet = 1'b1;
		run_random(TAIL_ITEMS);
		drain();

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tccw_pkg.sv
rtl/core/tccw_modu.sv
rtl/core/tccw_store.sv
rtl/core/text_console_cell_writer.sv
verif/tccw_checker.sv
verif/tb.sv
